### rtl/ihcv_pkg.sv
package ihcv_pkg;

  // counter width default and fixed constants
  localparam int unsigned CountWidth    = 19;
  localparam logic [31:0] CrcPoly       = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit       = 32'hFFFF_FFFF;
  localparam logic [31:0] MagicReset    = 32'h4F54_4131;
  localparam logic [31:0] StatusReset   = 32'hA5A5_A5A5;
  localparam logic [19:0] MaxBytesReset = 20'(480 * 1024);

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAGIC     = 2'd0,
    REG_STATUS    = 2'd1,
    REG_MAX_BYTES = 2'd2
  } cfg_reg_e;

  // item opcodes
  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } opcode_e;

  // result verdicts
  typedef enum logic [2:0] {
    VERDICT_HDR_OK   = 3'd0,
    VERDICT_BAD_ID   = 3'd1,
    VERDICT_BAD_SIZE = 3'd2,
    VERDICT_CRC_OK   = 3'd3,
    VERDICT_CRC_BAD  = 3'd4
  } verdict_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] hdr_magic;
    logic [31:0] hdr_size;
    logic [31:0] hdr_crc;
    logic [31:0] hdr_status;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] status;
    logic [19:0] max_bytes;
  } cfg_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] computed_crc;
  } result_t;

  // reflected crc-32 update by one byte, unrolled into an xor network
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] byte_in);
    logic [31:0] c;
    c = crc_in ^ {24'd0, byte_in};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

### rtl/ihcv_item_if.sv
interface ihcv_item_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] hdr_magic;
  logic [31:0] hdr_size;
  logic [31:0] hdr_crc;
  logic [31:0] hdr_status;
  logic [7:0]  data_byte;

  modport source (
    output valid, opcode, hdr_magic, hdr_size, hdr_crc, hdr_status, data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, hdr_magic, hdr_size, hdr_crc, hdr_status, data_byte,
    output ready
  );
endinterface

### rtl/ihcv_result_if.sv
interface ihcv_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [31:0] computed_crc;

  modport source (
    output valid, verdict, computed_crc,
    input  ready
  );
  modport sink (
    input  valid, verdict, computed_crc,
    output ready
  );
endinterface

### rtl/ihcv_cfg_regs.sv
module ihcv_cfg_regs import ihcv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode register writes, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAGIC:     cfg_d.magic     = cfg_wdata_i;
        REG_STATUS:    cfg_d.status    = cfg_wdata_i;
        REG_MAX_BYTES: cfg_d.max_bytes = cfg_wdata_i[19:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic     <= MagicReset;
      cfg_q.status    <= StatusReset;
      cfg_q.max_bytes <= MaxBytesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/ihcv_verify_unit.sv
module ihcv_verify_unit import ihcv_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam logic [32:0] CntCap = 33'(1) << COUNT_WIDTH;

  logic [31:0]            crc_q, crc_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [31:0]            exp_q, exp_d;
  logic                   armed_q, armed_d;

  logic        id_ok;
  logic        size_ok;
  logic [31:0] size_m1;
  logic [31:0] crc_next;
  logic [31:0] crc_final;

  // header checks
  assign id_ok   = (item_i.hdr_magic == cfg_i.magic) && (item_i.hdr_status == cfg_i.status);
  assign size_ok = (item_i.hdr_size != 32'd0)
                && (item_i.hdr_size <= {12'd0, cfg_i.max_bytes})
                && ({1'b0, item_i.hdr_size} <= CntCap);
  assign size_m1 = item_i.hdr_size - 32'd1;

  // byte-wide crc step
  assign crc_next  = crc_byte(crc_q, item_i.data_byte);
  assign crc_final = ~crc_next;

  // next state and verdict
  always_comb begin
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    exp_d       = exp_q;
    armed_d     = armed_q;
    res_valid_o = 1'b0;
    res_o.verdict      = VERDICT_HDR_OK;
    res_o.computed_crc = 32'd0;
    if (advance_i) begin
      if (item_i.opcode == OP_HEADER) begin
        res_valid_o = 1'b1;
        armed_d     = 1'b0;
        if (!id_ok) begin
          res_o.verdict = VERDICT_BAD_ID;
        end else if (!size_ok) begin
          res_o.verdict = VERDICT_BAD_SIZE;
        end else begin
          res_o.verdict = VERDICT_HDR_OK;
          armed_d       = 1'b1;
          crc_d         = CrcInit;
          cnt_d         = size_m1[COUNT_WIDTH-1:0];
          exp_d         = item_i.hdr_crc;
        end
      end else if (armed_q) begin
        crc_d = crc_next;
        if (cnt_q != '0) begin
          cnt_d = cnt_q - COUNT_WIDTH'(1);
        end else begin
          armed_d            = 1'b0;
          res_valid_o        = 1'b1;
          res_o.computed_crc = crc_final;
          res_o.verdict      = (crc_final == exp_q) ? VERDICT_CRC_OK : VERDICT_CRC_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInit;
      cnt_q   <= '0;
      exp_q   <= 32'd0;
      armed_q <= 1'b0;
    end else begin
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      exp_q   <= exp_d;
      armed_q <= armed_d;
    end
  end

  // a rejected header leaves the check disarmed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (item_i.opcode == OP_HEADER) && (res_o.verdict != VERDICT_HDR_OK)
    |=> !armed_q)
    else $error("rejected header left the check armed");

  // an accepted header arms with a fresh accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && res_valid_o && (res_o.verdict == VERDICT_HDR_OK)
    |=> armed_q && (crc_q == CrcInit))
    else $error("accepted header did not arm");

  // a stray data beat changes nothing and gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (item_i.opcode == OP_DATA) && !armed_q
    |=> $stable(crc_q) && $stable(cnt_q) && !$past(res_valid_o))
    else $error("unarmed data beat disturbed the check");

  // header verdicts carry no crc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && ((res_o.verdict == VERDICT_HDR_OK) || (res_o.verdict == VERDICT_BAD_ID) ||
                    (res_o.verdict == VERDICT_BAD_SIZE))
    |-> (res_o.computed_crc == 32'd0))
    else $error("header verdict with non-zero crc");

endmodule

### rtl/image_header_crc_verifier_core.sv
// Checks a staged image: a header beat is judged against the magic, status and
// maximum-size registers and, if good, arms a byte-wide reflected CRC-32 check
// over the following data beats; the last byte yields a match or mismatch
// verdict with the computed CRC. One beat is taken every cycle while the result
// register is free or being drained; a beat lands in the item register and its
// verdict is registered in the result register when it advances, with the
// single-byte CRC xor network between them setting the cycle time. Data beats
// with no check armed and data beats before the last give no result. The user
// must write configuration only while no beat is in flight; nothing enforces it.
module image_header_crc_verifier_core import ihcv_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  ihcv_item_if.sink     item_i,
  ihcv_result_if.source result_o
);

  cfg_t    cfg;
  item_t   item_q, item_d;
  logic    item_valid_q, item_valid_d;
  result_t res;
  logic    res_valid;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;
  logic    advance;

  ihcv_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // item stage moves on when the result register is free or being drained
  assign advance      = item_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !item_valid_q || advance;

  // input beat register
  always_comb begin
    item_d       = item_q;
    item_valid_d = item_valid_q;
    if (item_i.ready) begin
      item_valid_d     = item_i.valid;
      item_d.opcode    = item_i.opcode;
      item_d.hdr_magic = item_i.hdr_magic;
      item_d.hdr_size  = item_i.hdr_size;
      item_d.hdr_crc   = item_i.hdr_crc;
      item_d.hdr_status = item_i.hdr_status;
      item_d.data_byte = item_i.data_byte;
    end
  end

  ihcv_verify_unit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_verify_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (item_q),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.verdict      = out_q.verdict;
  assign result_o.computed_crc = out_q.computed_crc;

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihcv_pkg::*;

  // one queued beat for the sender, or a marker to wait for all verdicts
  typedef struct {
    bit    wait_clear;
    item_t body;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  ihcv_item_if   item_if ();
  ihcv_result_if res_if ();

  image_header_crc_verifier_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (res_if)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // register shadow, as the block should see it
  logic [31:0] cfg_magic  = MagicReset;
  logic [31:0] cfg_status = StatusReset;
  logic [19:0] cfg_max    = MaxBytesReset;

  // image check state
  logic [31:0]           img_crc      = CrcInit;
  logic [CountWidth-1:0] img_left     = '0;
  logic [31:0]           img_expected = '0;
  bit                    img_armed    = 1'b0;

  result_t     pending_verdicts[$];
  beat_t       beats_to_send[$];
  int unsigned sent_count = 0;
  int unsigned err_count  = 0;

  // sender and receiver state
  bit    item_taken = 1'b0;
  bit    verdict_taken = 1'b0;
  bit    have_item = 1'b0;
  bit    waiting_clear = 1'b0;
  item_t cur_item;
  int    gap_left = 0;
  int    send_run = 0;
  int    stall_left = 0;
  int    recv_run = 0;
  int    hold_left = 0;
  bit    hold_req = 1'b0;
  bit    hold_taken = 1'b0;

  task automatic report_error(string msg);
    if (err_count < 50) $display("tb: mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // reflected crc-32, one bit at a time
  function automatic logic [31:0] crc_update(logic [31:0] acc, logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      if (acc[0] ^ b[i]) acc = (acc >> 1) ^ CrcPoly;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  // random wait per beat, with runs of back-to-back beats
  function automatic int pick_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // work out the verdict, if any, that an accepted beat causes
  function automatic void judge_item(item_t it);
    result_t r;
    r.computed_crc = '0;
    r.verdict      = VERDICT_HDR_OK;
    if (it.opcode == OP_HEADER) begin
      img_armed = 1'b0;
      if (it.hdr_magic != cfg_magic || it.hdr_status != cfg_status) begin
        r.verdict = VERDICT_BAD_ID;
      end else if (it.hdr_size == 0 || it.hdr_size > {12'd0, cfg_max} ||
                   33'(it.hdr_size) > (33'd1 << CountWidth)) begin
        r.verdict = VERDICT_BAD_SIZE;
      end else begin
        img_armed    = 1'b1;
        img_crc      = CrcInit;
        img_left     = CountWidth'(it.hdr_size - 32'd1);
        img_expected = it.hdr_crc;
      end
      pending_verdicts.push_back(r);
    end else if (img_armed) begin
      img_crc = crc_update(img_crc, it.data_byte);
      if (img_left != 0) begin
        img_left--;
      end else begin
        img_armed      = 1'b0;
        r.computed_crc = ~img_crc;
        r.verdict      = (~img_crc == img_expected) ? VERDICT_CRC_OK : VERDICT_CRC_BAD;
        pending_verdicts.push_back(r);
      end
    end
  endfunction

  // monitor: predict on accepted item beats, check accepted result beats
  always @(posedge clk_i) begin
    item_t   seen;
    result_t want;
    item_taken    = rst_ni && item_if.valid && item_if.ready;
    verdict_taken = rst_ni && res_if.valid && res_if.ready;
    if (item_taken) begin
      seen.opcode     = item_if.opcode;
      seen.hdr_magic  = item_if.hdr_magic;
      seen.hdr_size   = item_if.hdr_size;
      seen.hdr_crc    = item_if.hdr_crc;
      seen.hdr_status = item_if.hdr_status;
      seen.data_byte  = item_if.data_byte;
      judge_item(seen);
    end
    if (verdict_taken) begin
      if (pending_verdicts.size() == 0) begin
        report_error($sformatf("result beat with none pending, verdict %0d",
                               res_if.verdict));
      end else begin
        want = pending_verdicts.pop_front();
        if (res_if.verdict !== want.verdict)
          report_error($sformatf("verdict %0d, wanted %0d", res_if.verdict, want.verdict));
        if (res_if.computed_crc !== want.computed_crc)
          report_error($sformatf("crc %h, wanted %h", res_if.computed_crc,
                                 want.computed_crc));
      end
    end
  end

  // sender: presents queued beats with a random gap before each
  always @(negedge clk_i) begin
    beat_t nxt;
    if (rst_ni) begin
      if (item_taken) have_item = 1'b0;
      if (!have_item) begin
        if (waiting_clear) begin
          waiting_clear = (pending_verdicts.size() != 0);
        end else if (beats_to_send.size() != 0) begin
          nxt = beats_to_send.pop_front();
          if (nxt.wait_clear) begin
            waiting_clear = 1'b1;
          end else begin
            cur_item  = nxt.body;
            have_item = 1'b1;
            gap_left  = pick_wait(send_run);
          end
        end
      end
      if (have_item && gap_left == 0) begin
        item_if.valid      <= 1'b1;
        item_if.opcode     <= cur_item.opcode;
        item_if.hdr_magic  <= cur_item.hdr_magic;
        item_if.hdr_size   <= cur_item.hdr_size;
        item_if.hdr_crc    <= cur_item.hdr_crc;
        item_if.hdr_status <= cur_item.hdr_status;
        item_if.data_byte  <= cur_item.data_byte;
      end else begin
        item_if.valid <= 1'b0;
        if (have_item) gap_left--;
      end
    end
  end

  // receiver: random stall after each result beat, one long hold on request
  always @(negedge clk_i) begin
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (verdict_taken) stall_left = pick_wait(recv_run);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 400;
      end
      if (hold_left != 0) hold_left--;
      else if (stall_left != 0) stall_left--;
      else rdy = 1'b1;
    end
    res_if.ready <= rdy;
  end

  task automatic send_header(logic [31:0] magic, logic [31:0] size, logic [31:0] crc,
                             logic [31:0] status);
    beat_t b;
    b.wait_clear      = 1'b0;
    b.body.opcode     = OP_HEADER;
    b.body.hdr_magic  = magic;
    b.body.hdr_size   = size;
    b.body.hdr_crc    = crc;
    b.body.hdr_status = status;
    b.body.data_byte  = 8'($urandom);
    beats_to_send.push_back(b);
    sent_count++;
  endtask

  // header fields of a data beat carry noise
  task automatic send_byte(logic [7:0] value, bit counted);
    beat_t b;
    b.wait_clear      = 1'b0;
    b.body.opcode     = OP_DATA;
    b.body.hdr_magic  = $urandom;
    b.body.hdr_size   = $urandom;
    b.body.hdr_crc    = $urandom;
    b.body.hdr_status = $urandom;
    b.body.data_byte  = value;
    beats_to_send.push_back(b);
    if (counted) sent_count++;
  endtask

  // well-formed image: header then bytes, optionally cut short
  task automatic send_image(int unsigned len, bit good, bit cut);
    logic [7:0]  bytes[$];
    logic [31:0] acc;
    int unsigned stop;
    acc = CrcInit;
    for (int unsigned i = 0; i < len; i++) begin
      bytes.push_back(8'($urandom));
      acc = crc_update(acc, bytes[i]);
    end
    send_header(cfg_magic, len, good ? ~acc : 32'($urandom), cfg_status);
    stop = cut ? $urandom_range(0, len - 1) : len;
    for (int unsigned i = 0; i < stop; i++) send_byte(bytes[i], 1'b1);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    logic [31:0] size;
    goal = sent_count + n;
    while (sent_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(32, 160) : $urandom_range(1, 12);
        if (cfg_max != 0 && len > cfg_max) len = cfg_max;
        send_image(len, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      end else if (pick < 75) begin
        send_header($urandom, $urandom, $urandom, $urandom);
      end else if (pick < 83) begin
        // one bit off in the magic or the status
        if ($urandom_range(0, 1))
          send_header(cfg_magic ^ (32'd1 << $urandom_range(0, 31)), $urandom_range(1, 8),
                      $urandom, cfg_status);
        else
          send_header(cfg_magic, $urandom_range(0, 8), $urandom,
                      cfg_status ^ (32'd1 << $urandom_range(0, 31)));
      end else if (pick < 92) begin
        // sizes at the limits, followed by up to three bytes, mostly too few to finish the check
        case ($urandom_range(0, 5))
          0:       size = 32'(cfg_max);
          1:       size = 32'(cfg_max) + 32'd1;
          2:       size = 32'h0008_0000;
          3:       size = 32'h0008_0001;
          4:       size = $urandom;
          default: size = $urandom_range(13, 600000);
        endcase
        send_header(cfg_magic, size, $urandom, cfg_status);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // wait until all beats are out, all verdicts back and the pipe has drained
  task automatic settle();
    while (beats_to_send.size() != 0 || have_item || waiting_clear ||
           pending_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAGIC:     cfg_magic  = value;
      REG_STATUS:    cfg_status = value;
      REG_MAX_BYTES: cfg_max    = value[19:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] magic, logic [31:0] status, logic [31:0] max_word);
    settle();
    write_reg(REG_MAGIC, magic);
    write_reg(REG_STATUS, status);
    write_reg(REG_MAX_BYTES, max_word);
  endtask

  // stimulus
  initial begin
    beat_t       marker;
    int unsigned spin;
    item_if.valid      = 1'b0;
    item_if.opcode     = OP_HEADER;
    item_if.hdr_magic  = '0;
    item_if.hdr_size   = '0;
    item_if.hdr_crc    = '0;
    item_if.hdr_status = '0;
    item_if.data_byte  = '0;
    res_if.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_MAGIC;
    cfg_wdata_i        = '0;

    // single-byte image that matches
    send_header(MagicReset, 32'd1, ~crc_update(CrcInit, 8'h00), StatusReset);
    send_byte(8'h00, 1'b1);
    // byte with no check armed is dropped
    send_byte(8'hFF, 1'b0);
    // magic and size both wrong: id check wins
    send_header(32'h0, 32'd0, 32'h0, StatusReset);
    send_header(MagicReset, 32'd4, 32'h0, 32'hFFFF_FFFF);
    send_header(MagicReset, 32'd0, 32'h0, StatusReset);
    // largest size accepted, abandoned by a new header mid-image
    send_header(MagicReset, 32'(MaxBytesReset), 32'h0, StatusReset);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_header(MagicReset, 32'd3, 32'hFFFF_FFFF, StatusReset);
    repeat (3) send_byte(8'hFF, 1'b1);
    send_header(MagicReset, 32'(MaxBytesReset) + 32'd1, 32'h0, StatusReset);
    send_header(MagicReset, 32'hFFFF_FFFF, 32'hFFFF_FFFF, StatusReset);
    // rejected header while armed leaves the block unarmed
    send_header(MagicReset, 32'd2, 32'h0, StatusReset);
    send_header(32'hFFFF_FFFF, 32'd2, 32'h0, StatusReset);
    send_byte(8'h5A, 1'b0);
    send_image(2, 1'b1, 1'b0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    random_traffic(230);

    // zero maximum: every header that passes the id check fails on size
    set_config(32'h0, 32'hFFFF_FFFF, 32'hFFF0_0000);
    send_header(32'h0, 32'd1, 32'h0, 32'hFFFF_FFFF);
    random_traffic(60);

    // maximum of one byte
    set_config(32'hFFFF_FFFF, 32'h0, 32'h0010_0001);
    send_image(1, 1'b1, 1'b0);
    send_header(32'hFFFF_FFFF, 32'd2, 32'h0, 32'h0);
    random_traffic(110);

    // widest maximum: counter capacity is the limit; receiver holds off meanwhile
    set_config($urandom, $urandom, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    repeat (40) send_header(cfg_magic, $urandom_range(0, 40), $urandom, cfg_status);
    send_header(cfg_magic, 32'h0008_0000, $urandom, cfg_status);
    send_byte(8'($urandom), 1'b1);
    send_header(cfg_magic, 32'h0008_0001, $urandom, cfg_status);
    random_traffic(140);

    // maximum equal to the counter capacity, with a pause for all verdicts
    set_config($urandom, $urandom, 32'h0008_0000);
    random_traffic(70);
    marker.wait_clear = 1'b1;
    marker.body       = '0;
    beats_to_send.push_back(marker);
    random_traffic(70);

    set_config($urandom, $urandom, $urandom_range(1, 64));
    random_traffic(140);

    set_config(MagicReset, StatusReset, 32'(MaxBytesReset));
    random_traffic(80);

    // drain
    while (beats_to_send.size() != 0 || have_item || waiting_clear) @(posedge clk_i);
    spin = 0;
    while (pending_verdicts.size() != 0 && spin < 5000) begin
      @(posedge clk_i);
      spin++;
    end
    if (pending_verdicts.size() != 0)
      report_error($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
rtl/ihcv_pkg.sv
rtl/ihcv_item_if.sv
rtl/ihcv_result_if.sv
rtl/ihcv_cfg_regs.sv
rtl/ihcv_verify_unit.sv
rtl/image_header_crc_verifier_core.sv
tb/tb.sv
